/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the bounded set store RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/bss_pkg.sv */
// ---------------------------------------------------------------------------
// Bounded set store package
// Request codes, field widths, controller states and control structs.
// ---------------------------------------------------------------------------
package bss_pkg;

    localparam int KIND_W  = 3;
    localparam int TALLY_W = 7;

    localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MEMBER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GREATER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LESS    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MOVE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic ins;
        logic rd_last;
        logic move;
        logic dec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic can_ins;
        logic can_rm;
        logic slot_last;
        logic out_free;
    } t_sts;

endpackage

/* rtl/bss_req_if.sv */
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat: kind and operand.
// ---------------------------------------------------------------------------
interface bss_req_if #(
    parameter int VALUE_BITS = 32
);
    import bss_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [KIND_W-1:0]            kind;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

/* rtl/bss_rsp_if.sv */
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat: flag, tally and size.
// ---------------------------------------------------------------------------
interface bss_rsp_if;
    import bss_pkg::*;

    logic               valid;
    logic               ready;
    logic               flag;
    logic [TALLY_W-1:0] tally;
    logic [TALLY_W-1:0] set_size;

    modport source (output valid, output flag, output tally, output set_size, input ready);
    modport sink   (input valid, input flag, input tally, input set_size, output ready);

endinterface

/* rtl/bss_ram.sv */
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bss_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bss_ctrl.sv */
// ---------------------------------------------------------------------------
// Bounded set store controller
// Sequences accept, scan, update and response for one request at a time.
// ---------------------------------------------------------------------------
module bss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  bss_pkg::t_sts i_sts,
    output bss_pkg::t_cmd o_cmd,
    output logic          o_req_ready
);
    import bss_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = ST_RESP;
                if (i_sts.can_ins) begin
                    o_cmd.ins = 1'b1;
                end else if (i_sts.can_rm) begin
                    if (i_sts.slot_last) begin
                        o_cmd.dec = 1'b1;
                    end else begin
                        o_cmd.rd_last = 1'b1;
                        n_state       = ST_MOVE;
                    end
                end
            end
            ST_MOVE: begin
                o_cmd.move = 1'b1;
                n_state    = ST_RESP;
            end
            ST_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/bss_dp.sv */
// ---------------------------------------------------------------------------
// Bounded set store datapath
// Entry memory, scan counter, comparator, size register and result register.
// ---------------------------------------------------------------------------
module bss_dp #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bss_pkg::t_cmd                i_cmd,
    output bss_pkg::t_sts                o_sts,
    input  logic [bss_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_flag,
    output logic [bss_pkg::TALLY_W-1:0]  o_tally,
    output logic [bss_pkg::TALLY_W-1:0]  o_set_size
);
    import bss_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KIND_W-1:0]            r_kind;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [CW-1:0]                r_used;
    logic [CW-1:0]                r_idx;
    logic                         r_cmp_vld;
    logic [AW-1:0]                r_cmp_idx;
    logic                         r_found;
    logic [AW-1:0]                r_slot;
    logic [CW-1:0]                r_tally;
    logic                         r_flag;
    logic                         r_out_vld;
    logic                         r_out_flag;
    logic [TALLY_W-1:0]           r_out_tally;
    logic [TALLY_W-1:0]           r_out_size;

    logic                         w_issue;
    logic [CW-1:0]                w_last;
    logic [AW-1:0]                w_raddr;
    logic [VALUE_BITS-1:0]        w_rdata;
    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [VALUE_BITS-1:0]        w_wdata;
    logic                         w_eq;
    logic                         w_hit;

    assign w_issue = i_cmd.scan && (r_idx != r_used);
    assign w_last  = r_used - CW'(1);
    assign w_raddr = i_cmd.rd_last ? w_last[AW-1:0] : r_idx[AW-1:0];
    assign w_we    = i_cmd.ins || i_cmd.move;
    assign w_waddr = i_cmd.ins ? r_used[AW-1:0] : r_slot;
    assign w_wdata = i_cmd.ins ? r_value : w_rdata;
    assign w_eq    = (w_rdata == r_value);
    assign w_hit   = ((r_kind == KIND_GREATER) && ($signed(w_rdata) > r_value)) ||
                     ((r_kind == KIND_LESS) && ($signed(w_rdata) < r_value));

    bss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + CW'(1);
        end
        r_cmp_idx <= r_idx[AW-1:0];
        if (i_cmd.load) begin
            r_tally <= '0;
            r_flag  <= 1'b0;
        end else begin
            if (r_cmp_vld && w_hit) begin
                r_tally <= r_tally + CW'(1);
            end
            if (i_cmd.ins || i_cmd.move || i_cmd.dec) begin
                r_flag <= 1'b1;
            end
        end
        if (r_cmp_vld && w_eq) begin
            r_slot <= r_cmp_idx;
        end
        if (i_cmd.emit) begin
            r_out_flag  <= r_flag || ((r_kind == KIND_MEMBER) && r_found);
            r_out_tally <= TALLY_W'(r_tally);
            r_out_size  <= TALLY_W'(r_used);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.ins) begin
                r_used <= r_used + CW'(1);
            end else if (i_cmd.move || i_cmd.dec) begin
                r_used <= w_last;
            end
            r_cmp_vld <= w_issue;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (r_cmp_vld && w_eq) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.scan_done = (r_idx == r_used) && !r_cmp_vld;
        o_sts.can_ins   = (r_kind == KIND_INSERT) && !r_found && (r_used < CW'(CAPACITY));
        o_sts.can_rm    = (r_kind == KIND_REMOVE) && r_found;
        o_sts.slot_last = (CW'(r_slot) == w_last);
        o_sts.out_free  = !r_out_vld || i_out_ready;
    end

    assign o_out_valid = r_out_vld;
    assign o_flag      = r_out_flag;
    assign o_tally     = r_out_tally;
    assign o_set_size  = r_out_size;

endmodule

/* rtl/bounded_set_store.sv */
// ---------------------------------------------------------------------------
// Bounded set store
// Set of distinct signed integers with insert, remove, member and rank count.
// ---------------------------------------------------------------------------
// The block takes one request beat at a time and answers each with one
// result beat. Every request walks the stored entries through the single
// read port of the entry memory, one entry per cycle. A remove that frees
// a slot other than the last moves the last entry into the freed slot.
// The next request can be taken once the result has been loaded. The
// result register lets a new request be accepted while the previous
// result still waits. Entries are kept unordered internally; results do
// not depend on the stored order. No clearing pass is needed after reset.
`include "assert_macros.svh"

module bounded_set_store #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    bss_req_if.sink   i_req,
    bss_rsp_if.source o_rsp
);
    import bss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_req_ready (w_ready)
    );

    bss_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_kind      (i_req.kind),
        .i_value     (i_req.value),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_flag      (o_rsp.flag),
        .o_tally     (o_rsp.tally),
        .o_set_size  (o_rsp.set_size)
    );

    assign i_req.ready = w_ready;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && w_ready, !w_ready, "request accepted while busy")
    `ASSERT_SAME(a_one_write, i_clk, i_rst_n, 1'b1, $onehot0({w_cmd.ins, w_cmd.move, w_cmd.dec}), "conflicting set updates")
    `ASSERT_SAME(a_emit_free, i_clk, i_rst_n, w_cmd.emit, w_sts.out_free, "result overwrites pending beat")

endmodule
